/* design/greedy_graph_vertex_partitioner_macros.svh */
// Assertion macros for the greedy graph vertex partitioner.
// No dependencies.
`ifndef GREEDY_GRAPH_VERTEX_PARTITIONER_MACROS_SVH
`define GREEDY_GRAPH_VERTEX_PARTITIONER_MACROS_SVH
`define GGVP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define GGVP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* design/ggvp_pkg.sv */
// Package for the greedy graph vertex partitioner: widths and codes.
// No dependencies.
`default_nettype none
package ggvp_pkg;
    localparam int MaxVertices = 4096;
    localparam int MaxParts    = 64;
    localparam int VW = $clog2(MaxVertices);
    localparam int PW = $clog2(MaxParts);
    localparam int CW = 13;
    localparam logic [CW-1:0] Sat = '1;
    typedef enum logic [1:0] {
        MODE_SEED   = 2'd0,
        MODE_ASSIGN = 2'd1,
        MODE_REFINE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;
    localparam logic CFG_NUM_PARTS = 1'b0;
    localparam logic CFG_CAPACITY  = 1'b1;
endpackage
`default_nettype wire

/* design/ggvp_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ggvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* design/greedy_graph_vertex_partitioner.sv */
// Channel   | signals                                              | dir
// in        | in_valid/in_ready, mode vertex neighbor neighbor_valid seed_part last | in
// out       | out_valid/out_ready, vertex_out part_out moved assigned | out
// cfg       | cfg_valid/cfg_ready, cfg_index cfg_data              | in
// Non-last transaction: vertex_part read, count read, then count and seen-list write.
// Last transaction: vertex_part read, scan of the S distinct neighbor parts seen, fallback
//   over num_parts, load update (old part decremented in refine), then a zeroing pass over S.
// After reset a clearing pass over all 4096 entries marks vertex_part unassigned and zeroes
// loads and counts; in_ready low. A result still waiting holds the block in S_OUT.
// Depends on ggvp_pkg, ggvp_ram and the macros header.
`default_nettype none
`include "greedy_graph_vertex_partitioner_macros.svh"
module greedy_graph_vertex_partitioner
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               mode,
    input  wire logic [ggvp_pkg::VW-1:0]  vertex,
    input  wire logic [ggvp_pkg::VW-1:0]  neighbor,
    input  wire logic                     neighbor_valid,
    input  wire logic [ggvp_pkg::PW-1:0]  seed_part,
    input  wire logic                     last,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [ggvp_pkg::VW-1:0]       vertex_out,
    output logic [ggvp_pkg::PW-1:0]       part_out,
    output logic                          moved,
    output logic                          assigned,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [12:0]              cfg_data
);
    import ggvp_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_NRD, S_NCNT, S_NUPD, S_VRD, S_VDEC, S_CUR, S_SCAN, S_SQ,
        S_SCMP, S_FALL, S_FCMP, S_COMMIT, S_INC, S_DRD, S_DEC, S_ZERO, S_ZWR, S_OUT
    } state_t;

    state_t state_reg;
    logic [6:0]  num_parts_reg;
    logic [12:0] capacity_reg;
    logic [PW:0]   seen_len_reg;
    logic [1:0]    mode_reg;
    logic [VW-1:0] vtx_reg;
    logic [VW-1:0] nb_reg;
    logic          nbv_reg, last_reg;
    logic [PW-1:0] seed_reg;
    logic [PW:0]   idx_reg;
    logic [VW:0]   clr_reg;
    logic          cur_ok_reg;
    logic [PW-1:0] cur_reg;
    logic          found_reg;
    logic [PW-1:0] best_reg;
    logic [CW-1:0] bcnt_reg, bload_reg;
    logic          moved_reg;
    logic [PW-1:0] np_reg;
    logic          nok_reg;
    logic [PW-1:0] q_reg;

    logic          ram_we;
    logic [VW-1:0] ram_addr;
    logic [PW:0]   ram_wdata, ram_rdata;

    logic          load_we;
    logic [PW-1:0] load_addr;
    logic [CW-1:0] load_wdata, load_rdata;

    logic          cnt_we;
    logic [PW-1:0] cnt_addr;
    logic [CW-1:0] cnt_wdata, cnt_rdata;

    logic          seen_we;
    logic [PW-1:0] seen_addr;
    logic [PW-1:0] seen_wdata, seen_rdata;

    logic [PW:0]   k;
    logic [12:0]   cap;
    logic          seen_add;
    logic [PW-1:0] q_sel;
    logic          q_room;

    assign k   = (num_parts_reg == '0) ? (PW+1)'(1) :
                 (num_parts_reg > 7'(MaxParts)) ? (PW+1)'(MaxParts) : num_parts_reg[PW:0];
    assign cap = (capacity_reg == '0) ? 13'd1 : capacity_reg;

    assign seen_add = nok_reg && (cnt_rdata == '0) && (seen_len_reg < (PW+1)'(MaxParts));
    assign q_sel    = (state_reg == S_FCMP) ? idx_reg[PW-1:0] : q_reg;
    assign q_room   = ({1'b0, q_sel} < k) && (load_rdata < cap);

    ggvp_ram #(.WIDTH(PW+1), .DEPTH(MaxVertices)) u_vpart (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    ggvp_ram #(.WIDTH(CW), .DEPTH(MaxParts)) u_load (
        .clk(clk), .we(load_we), .addr(load_addr), .wdata(load_wdata), .rdata(load_rdata)
    );

    ggvp_ram #(.WIDTH(CW), .DEPTH(MaxParts)) u_cnt (
        .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
    );

    ggvp_ram #(.WIDTH(PW), .DEPTH(MaxParts)) u_seen (
        .clk(clk), .we(seen_we), .addr(seen_addr), .wdata(seen_wdata), .rdata(seen_rdata)
    );

    always_comb
    begin
        ram_we     = 1'b0;
        ram_addr   = vtx_reg;
        ram_wdata  = {1'b0, best_reg};
        load_we    = 1'b0;
        load_addr  = best_reg;
        load_wdata = '0;
        cnt_we     = 1'b0;
        cnt_addr   = np_reg;
        cnt_wdata  = '0;
        seen_we    = 1'b0;
        seen_addr  = idx_reg[PW-1:0];
        seen_wdata = np_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg[VW-1:0];
                ram_wdata = {1'b1, {PW{1'b0}}};
                load_we   = 1'b1;
                load_addr = clr_reg[PW-1:0];
                cnt_we    = 1'b1;
                cnt_addr  = clr_reg[PW-1:0];
            end
            S_NRD:    ram_addr = nb_reg;
            S_NCNT:   cnt_addr = ram_rdata[PW-1:0];
            S_NUPD:
            begin
                cnt_we    = nok_reg && (cnt_rdata != Sat);
                cnt_wdata = cnt_rdata + 1'b1;
                seen_we   = seen_add;
                seen_addr = seen_len_reg[PW-1:0];
            end
            S_VDEC:   cnt_addr = ram_rdata[PW-1:0];
            S_SQ:
            begin
                cnt_addr  = seen_rdata;
                load_addr = seen_rdata;
            end
            S_FALL:   load_addr = idx_reg[PW-1:0];
            S_COMMIT: ram_we = moved_reg;
            S_INC:
            begin
                load_we    = 1'b1;
                load_wdata = (load_rdata != Sat) ? load_rdata + 1'b1 : load_rdata;
            end
            S_DRD:    load_addr = cur_reg;
            S_DEC:
            begin
                load_we    = 1'b1;
                load_addr  = cur_reg;
                load_wdata = (load_rdata != '0) ? load_rdata - 1'b1 : load_rdata;
            end
            S_ZWR:
            begin
                cnt_we   = 1'b1;
                cnt_addr = seen_rdata;
            end
            default:  ram_addr = vtx_reg;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            num_parts_reg <= 7'd2;
            capacity_reg  <= 13'd2048;
            seen_len_reg  <= '0;
            clr_reg       <= '0;
            out_valid     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NUM_PARTS) num_parts_reg <= cfg_data[6:0];
                else                            capacity_reg  <= cfg_data;
            end
            if (out_valid && out_ready && state_reg != S_OUT) out_valid <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (VW+1)'(MaxVertices - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg <= mode; vtx_reg <= vertex; nb_reg <= neighbor;
                        nbv_reg <= neighbor_valid; seed_reg <= seed_part; last_reg <= last;
                        state_reg <= S_NRD;
                    end
                end
                S_NRD: state_reg <= S_NCNT;
                S_NCNT:
                begin
                    np_reg    <= ram_rdata[PW-1:0];
                    nok_reg   <= (mode_reg == MODE_ASSIGN || mode_reg == MODE_REFINE) &&
                                 nbv_reg && nb_reg != vtx_reg && !ram_rdata[PW];
                    state_reg <= S_NUPD;
                end
                S_NUPD:
                begin
                    if (seen_add) seen_len_reg <= seen_len_reg + 1'b1;
                    state_reg <= last_reg ? S_VRD : S_IDLE;
                end
                S_VRD: state_reg <= S_VDEC;
                S_VDEC:
                begin
                    cur_ok_reg <= !ram_rdata[PW];
                    cur_reg    <= ram_rdata[PW-1:0];
                    idx_reg    <= '0;
                    found_reg  <= 1'b0;
                    moved_reg  <= 1'b0;
                    best_reg   <= ram_rdata[PW-1:0];
                    state_reg  <= S_COMMIT;
                    case (mode_reg)
                        MODE_SEED:
                            if (ram_rdata[PW] && {1'b0, seed_reg} < k)
                            begin
                                best_reg <= seed_reg; moved_reg <= 1'b1;
                            end
                        MODE_ASSIGN:  if (ram_rdata[PW]) state_reg <= S_SCAN;
                        MODE_REFINE:  if (!ram_rdata[PW]) state_reg <= S_CUR;
                        default: ;
                    endcase
                end
                S_CUR:
                begin
                    bcnt_reg  <= cnt_rdata;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (idx_reg == seen_len_reg)
                    begin
                        idx_reg <= '0;
                        if (mode_reg == MODE_REFINE)
                        begin
                            moved_reg <= (best_reg != cur_reg);
                            state_reg <= S_COMMIT;
                        end
                        else if (found_reg)
                        begin
                            moved_reg <= 1'b1;
                            state_reg <= S_COMMIT;
                        end
                        else
                        begin
                            best_reg  <= '0;
                            state_reg <= S_FALL;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    q_reg     <= seen_rdata;
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                    if (mode_reg == MODE_REFINE)
                    begin
                        if (q_reg != cur_reg && q_room && cnt_rdata > bcnt_reg)
                        begin
                            best_reg <= q_reg; bcnt_reg <= cnt_rdata;
                        end
                    end
                    else if (q_room && (!found_reg || cnt_rdata > bcnt_reg ||
                             (cnt_rdata == bcnt_reg && load_rdata < bload_reg)))
                    begin
                        found_reg <= 1'b1; best_reg <= q_reg;
                        bcnt_reg <= cnt_rdata; bload_reg <= load_rdata;
                    end
                end
                S_FALL:
                begin
                    if (idx_reg == k)
                    begin
                        moved_reg <= 1'b1;
                        state_reg <= S_COMMIT;
                    end
                    else
                    begin
                        state_reg <= S_FCMP;
                    end
                end
                S_FCMP:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_FALL;
                    if (q_room && (!found_reg || load_rdata < bload_reg))
                    begin
                        found_reg <= 1'b1; best_reg <= idx_reg[PW-1:0]; bload_reg <= load_rdata;
                    end
                end
                S_COMMIT:
                begin
                    idx_reg   <= '0;
                    state_reg <= moved_reg ? S_INC : S_ZERO;
                end
                S_INC: state_reg <= (mode_reg == MODE_REFINE) ? S_DRD : S_ZERO;
                S_DRD: state_reg <= S_DEC;
                S_DEC: state_reg <= S_ZERO;
                S_ZERO:
                begin
                    if (idx_reg == seen_len_reg)
                    begin
                        seen_len_reg <= '0;
                        state_reg <= (mode_reg == MODE_NONE) ? S_IDLE : S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ZWR;
                    end
                end
                S_ZWR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_ZERO;
                end
                S_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid  <= 1'b1;
                        vertex_out <= vtx_reg;
                        moved      <= moved_reg;
                        assigned   <= moved_reg || cur_ok_reg;
                        part_out   <= moved_reg ? best_reg : (cur_ok_reg ? cur_reg : '0);
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `GGVP_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `GGVP_ASSERT_IMP(a_seen_bound, clk, rst_n, 1'b1, seen_len_reg <= (PW+1)'(MaxParts))
    `GGVP_ASSERT_NEXT(a_zero_clears, clk, rst_n,
        state_reg == S_ZERO && idx_reg == seen_len_reg, seen_len_reg == '0)
    `GGVP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire
